### hdl/bba_pkg.sv
// Shared types and constants for the buddy block allocator.
// Depends on nothing; used by buddy_block_allocator, bba_checker and the testbench top.
package bba_pkg;

	// Table geometry.
	localparam int NUM_BLOCKS = 1024;
	localparam int NUM_ORDERS = 11;
	localparam int IDX_W      = $clog2(NUM_BLOCKS);
	localparam int LINK_W     = IDX_W + 1;
	localparam int ORD_W      = 4;
	localparam int HEAD_AW    = $clog2(NUM_ORDERS);
	localparam int BN_W       = 20;
	localparam int LIM_W      = 21;
	localparam int STATUS_W   = 2;

	localparam logic [ORD_W-1:0]  ORDER_UNLISTED = 4'd15;
	localparam logic [LINK_W-1:0] LINK_NULL      = LINK_W'(NUM_BLOCKS);

	// Commands, status codes and configuration register indexes.
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_MEM  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

	localparam logic CFG_HEAP_START = 1'b0;
	localparam logic CFG_HEAP_END   = 1'b1;

	// Request and response words.
	typedef struct packed {
		logic             command;
		logic [ORD_W-1:0] order;
		logic [BN_W-1:0]  block_number;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BN_W-1:0]     block_number_res;
	} rsp_t;

	// One table entry: list order, in-use flag and the two list links.
	typedef struct packed {
		logic [ORD_W-1:0]  order;
		logic              in_use;
		logic [LINK_W-1:0] next;
		logic [LINK_W-1:0] prev;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Sequencer states.
	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_FR_RD,
		S_FR_CHK,
		S_MG_CHK,
		S_MG_RD,
		S_UL_RD,
		S_UL_WR,
		S_UL_NRD,
		S_UL_NWR,
		S_UL_PRD,
		S_UL_PWR,
		S_SPLIT,
		S_PUSH,
		S_PS_RD,
		S_PS_WR,
		S_OUT
	} state_t;

endpackage

### hdl/buddy_block_allocator.sv
// Buddy allocator top level: request sequencer around one block table RAM.
// Depends on bba_pkg and bba_ram.
//
// Usage. Requests arrive as words on in_valid/in_ready/in_data: allocate a
// block of a given order, or free one by absolute block number. Each word
// yields exactly one response word on out_valid/out_ready/out_data.
// The heap bounds are written on the cfg channel, which is always ready.
//
// Sequencing. One request is handled at a time; a new word is
// taken only after the previous response has been taken. Table steps are
// reads or writes of the single-port table RAM, whose read data is
// registered. A request refused at once goes straight to its response,
// and a free is first checked against its table entry. An allocation
// unlinks the found block, then pushes each split-off half in the table;
// a free clears the in-use flag, unlinks and merges a listed buddy of
// equal order per level, then pushes the merged block.
//
// Reset. After arst_n is released a clearing pass over all 1024 entries
// marks every table entry as allocated and unlisted; in_ready stays low
// during that pass, while configuration writes are taken as ever.
//
// Stalls. The response is held in an output register until out_ready is
// seen high; no new request is taken meanwhile.
module buddy_block_allocator (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  bba_pkg::req_t            in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output bba_pkg::rsp_t            out_data,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     cfg_index,
	input  logic [bba_pkg::LIM_W-1:0] cfg_data
);

	bba_pkg::state_t state_q, state_d;

	logic [bba_pkg::IDX_W-1:0]  clr_q;
	logic [bba_pkg::BN_W-1:0]   base_blk_q;
	logic [bba_pkg::LIM_W-1:0]  top_blk_q;
	logic [bba_pkg::LINK_W-1:0] head_q [bba_pkg::NUM_ORDERS];
	logic                       mode_q;
	logic [bba_pkg::ORD_W-1:0]  ord_q;
	logic [bba_pkg::ORD_W-1:0]  lvl_q;
	logic [bba_pkg::IDX_W-1:0]  h_q;
	logic [bba_pkg::BN_W-1:0]   bn_q;
	logic [bba_pkg::IDX_W-1:0]  bidx_q;
	logic [bba_pkg::LINK_W-1:0] n_q;
	logic [bba_pkg::LINK_W-1:0] p_q;
	logic [bba_pkg::IDX_W-1:0]  split_q;
	bba_pkg::rsp_t              rsp_q;

	// Table RAM port.
	logic                       ram_en;
	logic                       ram_we;
	logic [bba_pkg::IDX_W-1:0]  ram_addr;
	bba_pkg::entry_t            ram_wdata;
	bba_pkg::entry_t            ram_rdata;

	bba_ram #(
		.WIDTH(bba_pkg::ENTRY_W),
		.DEPTH(bba_pkg::NUM_BLOCKS)
	) u_table (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Effective heap limit and heap-relative indexes.
	logic [bba_pkg::LIM_W-1:0]  start_ext;
	logic [bba_pkg::LIM_W-1:0]  start_plus;
	logic [bba_pkg::LIM_W-1:0]  heap_lim;
	logic [bba_pkg::LIM_W-1:0]  in_bn_ext;
	logic                       in_bn_ok;
	logic [bba_pkg::BN_W-1:0]   buddy;
	logic [bba_pkg::LIM_W-1:0]  buddy_ext;
	logic                       buddy_ok;
	logic                       merge_stop;
	logic [bba_pkg::BN_W-1:0]   buddy_off;
	logic [bba_pkg::BN_W-1:0]   bn_off;
	logic [bba_pkg::BN_W-1:0]   in_off;
	logic [bba_pkg::IDX_W-1:0]  fr_idx;
	logic                       is_alloc;

	assign start_ext  = {1'b0, base_blk_q};
	assign start_plus = start_ext + bba_pkg::LIM_W'(bba_pkg::NUM_BLOCKS);
	assign heap_lim   = (top_blk_q < start_plus) ? top_blk_q : start_plus;
	assign in_bn_ext  = {1'b0, in_data.block_number};
	assign in_bn_ok   = (in_bn_ext >= start_ext) && (in_bn_ext < heap_lim);
	assign buddy      = bn_q ^ (bba_pkg::BN_W'(1) << ord_q);
	assign buddy_ext  = {1'b0, buddy};
	assign buddy_ok   = (buddy_ext >= start_ext) && (buddy_ext < heap_lim);
	assign merge_stop = (int'(ord_q) + 1 >= bba_pkg::NUM_ORDERS) || !buddy_ok;
	assign buddy_off  = buddy - base_blk_q;
	assign bn_off     = bn_q - base_blk_q;
	assign in_off     = in_data.block_number - base_blk_q;
	assign fr_idx     = bn_off[bba_pkg::IDX_W-1:0];
	assign is_alloc   = (mode_q == bba_pkg::CMD_ALLOC);

	// Search the free lists upward from the requested order.
	logic                        found;
	logic [bba_pkg::ORD_W-1:0]   found_ord;
	logic                        order_bad;

	always_comb begin
		found     = 1'b0;
		found_ord = '0;
		for (int i = bba_pkg::NUM_ORDERS - 1; i >= 0; i--) begin
			if ((bba_pkg::ORD_W'(i) >= in_data.order) &&
			    (head_q[i] < bba_pkg::LINK_NULL)) begin
				found     = 1'b1;
				found_ord = bba_pkg::ORD_W'(i);
			end
		end
	end

	assign order_bad = (int'(in_data.order) >= bba_pkg::NUM_ORDERS);

	// Unlink and push operands depend on whether an allocation or a free runs.
	logic [bba_pkg::IDX_W-1:0]   ul_idx;
	logic [bba_pkg::ORD_W-1:0]   ul_ord;
	logic [bba_pkg::IDX_W-1:0]   ps_idx;
	logic [bba_pkg::ORD_W-1:0]   ps_ord;
	logic [bba_pkg::LINK_W-1:0]  ps_old;
	logic [bba_pkg::ORD_W-1:0]   lvl_dec;
	logic [bba_pkg::LINK_W-1:0]  split_b;
	logic [bba_pkg::ORD_W-1:0]   ord_inc;
	logic [bba_pkg::BN_W-1:0]    bn_merged;

	assign ul_idx    = is_alloc ? h_q : bidx_q;
	assign ul_ord    = is_alloc ? lvl_q : ord_q;
	assign ps_idx    = is_alloc ? split_q : fr_idx;
	assign ps_ord    = is_alloc ? lvl_q : ord_q;
	assign ps_old    = head_q[ps_ord[bba_pkg::HEAD_AW-1:0]];
	assign lvl_dec   = lvl_q - 1'b1;
	assign split_b   = {1'b0, h_q} + (bba_pkg::LINK_W'(1) << lvl_dec);
	assign ord_inc   = ord_q + 1'b1;
	assign bn_merged = bn_q & ~((bba_pkg::BN_W'(1) << ord_inc) - 1'b1);

	// Unlink finishes when the predecessor is null or has been patched.
	logic ul_done;
	assign ul_done = ((state_q == bba_pkg::S_UL_PRD) && !(p_q < bba_pkg::LINK_NULL)) ||
	                 (state_q == bba_pkg::S_UL_PWR);

	// Next state and table accesses.
	always_comb begin
		state_d   = state_q;
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = '0;
		ram_wdata = ram_rdata;
		unique case (state_q)
			bba_pkg::S_CLEAR: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '{order: bba_pkg::ORDER_UNLISTED, in_use: 1'b1,
				              next: '0, prev: '0};
				if (clr_q == bba_pkg::IDX_W'(bba_pkg::NUM_BLOCKS - 1)) begin
					state_d = bba_pkg::S_IDLE;
				end
			end
			bba_pkg::S_IDLE: begin
				if (in_valid) begin
					if (order_bad) begin
						state_d = bba_pkg::S_OUT;
					end else if (in_data.command == bba_pkg::CMD_ALLOC) begin
						state_d = found ? bba_pkg::S_UL_RD : bba_pkg::S_OUT;
					end else begin
						state_d = in_bn_ok ? bba_pkg::S_FR_RD : bba_pkg::S_OUT;
					end
				end
			end
			bba_pkg::S_FR_RD: begin
				ram_en   = 1'b1;
				ram_addr = fr_idx;
				state_d  = bba_pkg::S_FR_CHK;
			end
			bba_pkg::S_FR_CHK: begin
				if ((ram_rdata.order != bba_pkg::ORDER_UNLISTED) || !ram_rdata.in_use) begin
					state_d = bba_pkg::S_OUT;
				end else begin
					ram_en           = 1'b1;
					ram_we           = 1'b1;
					ram_addr         = fr_idx;
					ram_wdata.in_use = 1'b0;
					state_d          = bba_pkg::S_MG_CHK;
				end
			end
			bba_pkg::S_MG_CHK: begin
				if (merge_stop) begin
					state_d = bba_pkg::S_PUSH;
				end else begin
					ram_en   = 1'b1;
					ram_addr = buddy_off[bba_pkg::IDX_W-1:0];
					state_d  = bba_pkg::S_MG_RD;
				end
			end
			bba_pkg::S_MG_RD: begin
				// The read word is held, so the unlink can use it directly.
				state_d = (ram_rdata.order == ord_q) ? bba_pkg::S_UL_WR : bba_pkg::S_PUSH;
			end
			bba_pkg::S_UL_RD: begin
				ram_en   = 1'b1;
				ram_addr = ul_idx;
				state_d  = bba_pkg::S_UL_WR;
			end
			bba_pkg::S_UL_WR: begin
				ram_en          = 1'b1;
				ram_we          = 1'b1;
				ram_addr        = ul_idx;
				ram_wdata.order = bba_pkg::ORDER_UNLISTED;
				if (is_alloc) begin
					ram_wdata.in_use = 1'b1;
				end
				state_d = bba_pkg::S_UL_NRD;
			end
			bba_pkg::S_UL_NRD: begin
				if (n_q < bba_pkg::LINK_NULL) begin
					ram_en   = 1'b1;
					ram_addr = n_q[bba_pkg::IDX_W-1:0];
					state_d  = bba_pkg::S_UL_NWR;
				end else begin
					state_d = bba_pkg::S_UL_PRD;
				end
			end
			bba_pkg::S_UL_NWR: begin
				ram_en         = 1'b1;
				ram_we         = 1'b1;
				ram_addr       = n_q[bba_pkg::IDX_W-1:0];
				ram_wdata.prev = p_q;
				state_d        = bba_pkg::S_UL_PRD;
			end
			bba_pkg::S_UL_PRD: begin
				if (p_q < bba_pkg::LINK_NULL) begin
					ram_en   = 1'b1;
					ram_addr = p_q[bba_pkg::IDX_W-1:0];
					state_d  = bba_pkg::S_UL_PWR;
				end else begin
					state_d = is_alloc ? bba_pkg::S_SPLIT : bba_pkg::S_MG_CHK;
				end
			end
			bba_pkg::S_UL_PWR: begin
				ram_en         = 1'b1;
				ram_we         = 1'b1;
				ram_addr       = p_q[bba_pkg::IDX_W-1:0];
				ram_wdata.next = n_q;
				state_d        = is_alloc ? bba_pkg::S_SPLIT : bba_pkg::S_MG_CHK;
			end
			bba_pkg::S_SPLIT: begin
				if (lvl_q > ord_q) begin
					if (split_b < bba_pkg::LINK_NULL) begin
						state_d = bba_pkg::S_PUSH;
					end
				end else begin
					state_d = bba_pkg::S_OUT;
				end
			end
			bba_pkg::S_PUSH: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = ps_idx;
				ram_wdata = '{order: ps_ord, in_use: 1'b0, next: ps_old,
				              prev: bba_pkg::LINK_NULL};
				if (ps_old < bba_pkg::LINK_NULL) begin
					state_d = bba_pkg::S_PS_RD;
				end else begin
					state_d = is_alloc ? bba_pkg::S_SPLIT : bba_pkg::S_OUT;
				end
			end
			bba_pkg::S_PS_RD: begin
				ram_en   = 1'b1;
				ram_addr = n_q[bba_pkg::IDX_W-1:0];
				state_d  = bba_pkg::S_PS_WR;
			end
			bba_pkg::S_PS_WR: begin
				ram_en         = 1'b1;
				ram_we         = 1'b1;
				ram_addr       = n_q[bba_pkg::IDX_W-1:0];
				ram_wdata.prev = {1'b0, ps_idx};
				state_d        = is_alloc ? bba_pkg::S_SPLIT : bba_pkg::S_OUT;
			end
			bba_pkg::S_OUT: begin
				if (out_ready) begin
					state_d = bba_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bba_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bba_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Clearing pass counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == bba_pkg::S_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_blk_q <= '0;
			top_blk_q  <= bba_pkg::LIM_W'(1024);
		end else if (cfg_valid) begin
			if (cfg_index == bba_pkg::CFG_HEAP_START) begin
				base_blk_q <= cfg_data[bba_pkg::BN_W-1:0];
			end else begin
				top_blk_q <= cfg_data;
			end
		end
	end

	// Free list heads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bba_pkg::NUM_ORDERS; i++) begin
				head_q[i] <= bba_pkg::LINK_NULL;
			end
		end else if (state_q == bba_pkg::S_PUSH) begin
			head_q[ps_ord[bba_pkg::HEAD_AW-1:0]] <= {1'b0, ps_idx};
		end else if ((state_q == bba_pkg::S_UL_PRD) && !(p_q < bba_pkg::LINK_NULL)) begin
			head_q[ul_ord[bba_pkg::HEAD_AW-1:0]] <= n_q;
		end
	end

	// Request working registers and the response register.
	always_ff @(posedge clk) begin
		unique case (state_q)
			bba_pkg::S_IDLE: begin
				mode_q       <= in_data.command;
				ord_q        <= in_data.order;
				lvl_q        <= found_ord;
				h_q          <= head_q[found_ord[bba_pkg::HEAD_AW-1:0]][bba_pkg::IDX_W-1:0];
				bn_q         <= in_data.block_number;
				bidx_q       <= in_off[bba_pkg::IDX_W-1:0];
				rsp_q.block_number_res <= '0;
				if (order_bad) begin
					rsp_q.status <= bba_pkg::ST_INVALID;
				end else if (in_data.command == bba_pkg::CMD_ALLOC) begin
					rsp_q.status <= found ? bba_pkg::ST_DONE : bba_pkg::ST_NO_MEM;
				end else begin
					rsp_q.status <= in_bn_ok ? bba_pkg::ST_DONE : bba_pkg::ST_INVALID;
				end
			end
			bba_pkg::S_FR_CHK: begin
				if ((ram_rdata.order != bba_pkg::ORDER_UNLISTED) || !ram_rdata.in_use) begin
					rsp_q.status <= bba_pkg::ST_INVALID;
				end
			end
			bba_pkg::S_MG_CHK: begin
				bidx_q <= buddy_off[bba_pkg::IDX_W-1:0];
			end
			bba_pkg::S_UL_WR: begin
				n_q <= ram_rdata.next;
				p_q <= ram_rdata.prev;
			end
			bba_pkg::S_SPLIT: begin
				if (lvl_q > ord_q) begin
					lvl_q   <= lvl_dec;
					split_q <= split_b[bba_pkg::IDX_W-1:0];
				end else begin
					rsp_q.block_number_res <= base_blk_q + bba_pkg::BN_W'(h_q);
				end
			end
			bba_pkg::S_PUSH: begin
				// Keep the old head for the back-link patch.
				n_q <= ps_old;
			end
			default: begin
			end
		endcase
		// A free's merge step ends every unlink it starts.
		if (ul_done && !is_alloc) begin
			ord_q <= ord_inc;
			bn_q  <= bn_merged;
		end
	end

	assign in_ready  = (state_q == bba_pkg::S_IDLE);
	assign out_valid = (state_q == bba_pkg::S_OUT);
	assign out_data  = rsp_q;
	assign cfg_ready = 1'b1;

endmodule

### hdl/bba_ram.sv
// Generic single-port RAM with a registered read port.
// Stand-alone; the read register holds its value until the next read.
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// A cycle either writes or reads, never both.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

### tb/bba_checker.sv
// Checker for the buddy block allocator: watches the request, response and
// configuration channels, predicts every response and compares it.
// Depends on bba_pkg for the word types, codes and table geometry.
module bba_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  bba_pkg::req_t             in_data,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  bba_pkg::rsp_t             out_data,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic                      cfg_index,
	input  logic [bba_pkg::LIM_W-1:0] cfg_data,
	output int                        errors,
	output int                        pending
);

	localparam longint BN_MASK = (longint'(1) << bba_pkg::BN_W) - 1;

	// Shadow copy of the block table, the free list heads and the heap bounds.
	logic [bba_pkg::ORD_W-1:0] shadow_order [bba_pkg::NUM_BLOCKS];
	bit                        shadow_in_use [bba_pkg::NUM_BLOCKS];
	int                        shadow_next [bba_pkg::NUM_BLOCKS];
	int                        shadow_prev [bba_pkg::NUM_BLOCKS];
	int                        free_head [bba_pkg::NUM_ORDERS];
	longint                    base_blk;
	longint                    top_blk;
	bba_pkg::rsp_t             expected_rsp [$];

	function automatic void list_insert(int idx, int o);
		int h;
		if (idx < 0 || idx >= bba_pkg::NUM_BLOCKS || o >= bba_pkg::NUM_ORDERS)
			return;
		h = free_head[o];
		shadow_next[idx] = h;
		shadow_prev[idx] = bba_pkg::NUM_BLOCKS;
		if (h < bba_pkg::NUM_BLOCKS)
			shadow_prev[h] = idx;
		free_head[o] = idx;
		shadow_order[idx] = bba_pkg::ORD_W'(o);
	endfunction

	function automatic void list_remove(int idx, int o);
		int n;
		int p;
		if (idx < 0 || idx >= bba_pkg::NUM_BLOCKS || o >= bba_pkg::NUM_ORDERS)
			return;
		n = shadow_next[idx];
		p = shadow_prev[idx];
		if (n < bba_pkg::NUM_BLOCKS)
			shadow_prev[n] = p;
		if (p < bba_pkg::NUM_BLOCKS)
			shadow_next[p] = n;
		else
			free_head[o] = n;
		shadow_order[idx] = bba_pkg::ORDER_UNLISTED;
	endfunction

	// Pops the lowest usable list and splits the block down to the asked order.
	function automatic bba_pkg::rsp_t allocate_block(int o);
		bba_pkg::rsp_t r;
		int i;
		int h;
		int b;
		r = '0;
		i = o;
		while (i < bba_pkg::NUM_ORDERS && free_head[i] >= bba_pkg::NUM_BLOCKS)
			i++;
		if (i >= bba_pkg::NUM_ORDERS) begin
			r.status = bba_pkg::ST_NO_MEM;
			return r;
		end
		h = free_head[i];
		list_remove(h, i);
		shadow_in_use[h] = 1'b1;
		while (i > o) begin
			i--;
			b = h + (1 << i);
			if (b < bba_pkg::NUM_BLOCKS) begin
				shadow_in_use[b] = 1'b0;
				list_insert(b, i);
			end
		end
		r.status = bba_pkg::ST_DONE;
		r.block_number_res = bba_pkg::BN_W'((base_blk + h) & BN_MASK);
		return r;
	endfunction

	// Releases a block and merges it with listed buddies of equal order.
	function automatic logic [bba_pkg::STATUS_W-1:0] release_block(int o, longint bn);
		longint lim;
		longint buddy;
		int idx;
		int bidx;
		lim = base_blk + bba_pkg::NUM_BLOCKS;
		if (top_blk < lim)
			lim = top_blk;
		if (bn < base_blk || bn >= lim)
			return bba_pkg::ST_INVALID;
		idx = int'(bn - base_blk);
		if (idx >= bba_pkg::NUM_BLOCKS || shadow_order[idx] != bba_pkg::ORDER_UNLISTED ||
		    !shadow_in_use[idx])
			return bba_pkg::ST_INVALID;
		shadow_in_use[idx] = 1'b0;
		while (o + 1 < bba_pkg::NUM_ORDERS) begin
			buddy = bn ^ (longint'(1) << o);
			if (buddy < base_blk || buddy >= lim)
				break;
			bidx = int'(buddy - base_blk);
			if (bidx >= bba_pkg::NUM_BLOCKS || shadow_order[bidx] != bba_pkg::ORD_W'(o))
				break;
			list_remove(bidx, o);
			o++;
			bn &= ~((longint'(1) << o) - 1);
		end
		list_insert(int'(bn - base_blk), o);
		return bba_pkg::ST_DONE;
	endfunction

	function automatic bba_pkg::rsp_t predict_response(bba_pkg::req_t w);
		bba_pkg::rsp_t r;
		r = '0;
		if (int'(w.order) >= bba_pkg::NUM_ORDERS)
			r.status = bba_pkg::ST_INVALID;
		else if (w.command == bba_pkg::CMD_ALLOC)
			r = allocate_block(int'(w.order));
		else
			r.status = release_block(int'(w.order), longint'(w.block_number));
		return r;
	endfunction

	// Requests are predicted before responses are compared on the same edge.
	always @(posedge clk) begin
		bba_pkg::rsp_t exp_w;
		if (!arst_n) begin
			for (int i = 0; i < bba_pkg::NUM_BLOCKS; i++) begin
				shadow_order[i] = bba_pkg::ORDER_UNLISTED;
				shadow_in_use[i] = 1'b1;
				shadow_next[i] = 0;
				shadow_prev[i] = 0;
			end
			for (int i = 0; i < bba_pkg::NUM_ORDERS; i++)
				free_head[i] = bba_pkg::NUM_BLOCKS;
			base_blk = 0;
			top_blk = 1024;
			expected_rsp.delete();
			errors <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == bba_pkg::CFG_HEAP_START)
					base_blk = longint'(cfg_data[bba_pkg::BN_W-1:0]);
				else
					top_blk = longint'(cfg_data);
			end
			if (in_valid && in_ready)
				expected_rsp.push_back(predict_response(in_data));
			if (out_valid && out_ready) begin
				if (expected_rsp.size() == 0) begin
					$error("response word with nothing expected: status %0d block %0d",
						out_data.status, out_data.block_number_res);
					errors <= errors + 1;
				end else begin
					exp_w = expected_rsp.pop_front();
					if (out_data.status !== exp_w.status) begin
						$error("status: expected %0d, got %0d", exp_w.status, out_data.status);
						errors <= errors + 1;
					end else if (out_data.block_number_res !== exp_w.block_number_res) begin
						$error("block_number_res: expected %0d, got %0d",
							exp_w.block_number_res, out_data.block_number_res);
						errors <= errors + 1;
					end
				end
			end
		end
		pending <= expected_rsp.size();
	end

endmodule

### tb/buddy_block_allocator_test.sv
// Top of the buddy block allocator testbench: clock, reset, stimulus and verdict.
// Depends on bba_pkg, buddy_block_allocator and bba_checker.
module buddy_block_allocator_test;

	localparam int WATCHDOG_LIMIT = 5000;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	bba_pkg::req_t             in_data = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	bba_pkg::rsp_t             out_data;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic                      cfg_index = bba_pkg::CFG_HEAP_START;
	logic [bba_pkg::LIM_W-1:0] cfg_data = '0;
	int                        errors;
	int                        pending;

	int                        send_idle_pct = 0;
	int                        recv_idle_pct = 0;
	int                        quiet_cycles = 0;
	int                        heap_lo;
	int                        heap_span;
	bba_pkg::req_t             sent_words [$];
	bba_pkg::req_t             granted [$];

	buddy_block_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bba_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The receiver stalls at random.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Granted blocks are remembered so that later frees are well formed.
	always @(posedge clk) begin
		bba_pkg::req_t w;
		if (out_valid && out_ready && sent_words.size() != 0) begin
			w = sent_words.pop_front();
			if (w.command == bba_pkg::CMD_ALLOC && out_data.status == bba_pkg::ST_DONE) begin
				w.command = bba_pkg::CMD_FREE;
				w.block_number = out_data.block_number_res;
				granted.push_back(w);
			end
		end
	end

	// Ends the run when no word has moved on any channel for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL buddy_block_allocator");
			$finish;
		end
	end

	task automatic send_word(input logic cmd, input int o, input int bn);
		bba_pkg::req_t w;
		int gap;
		w.command = cmd;
		w.order = bba_pkg::ORD_W'(o);
		w.block_number = bba_pkg::BN_W'(bn);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		sent_words.push_back(w);
	endtask

	// Holds the sender back until every expected response has come.
	task automatic drain_responses();
		in_valid <= 1'b0;
		@(posedge clk);
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic idx, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= bba_pkg::LIM_W'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_heap(input int lo, input int hi);
		drain_responses();
		write_register(bba_pkg::CFG_HEAP_START, lo);
		write_register(bba_pkg::CFG_HEAP_END, hi);
		granted.delete();
	endtask

	// Mostly well-formed allocations and frees over the current heap, plus noise.
	task automatic random_traffic(input int count);
		int r;
		int k;
		bba_pkg::req_t g;
		for (int n = 0; n < count; n++) begin
			if (n == count / 2)
				drain_responses();
			r = $urandom_range(99);
			if (r < 45) begin
				if ($urandom_range(9) != 0)
					send_word(bba_pkg::CMD_ALLOC, $urandom_range(0, 5), $urandom);
				else
					send_word(bba_pkg::CMD_ALLOC, $urandom_range(0, 15), $urandom);
			end else if (r < 85 && granted.size() != 0) begin
				k = $urandom_range(0, granted.size() - 1);
				g = granted[k];
				granted.delete(k);
				if ($urandom_range(19) == 0)
					send_word(bba_pkg::CMD_FREE, $urandom_range(0, 15),
						int'(g.block_number));
				else
					send_word(bba_pkg::CMD_FREE, int'(g.order), int'(g.block_number));
			end else if (r < 93) begin
				send_word(bba_pkg::CMD_FREE, $urandom_range(0, 3),
					heap_lo + $urandom_range(0, heap_span - 1));
			end else begin
				send_word(1'($urandom_range(0, 1)), $urandom_range(0, 15),
					$urandom_range(0, 1048575));
			end
		end
	endtask

	initial begin
		int fill [$];
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words at the reset-sized heap.
		set_heap(0, 1024);
		send_word(bba_pkg::CMD_ALLOC, 0, 0);
		send_word(bba_pkg::CMD_ALLOC, 15, 1048575);
		send_word(bba_pkg::CMD_FREE, 11, 0);
		send_word(bba_pkg::CMD_FREE, 0, 1048575);
		send_word(bba_pkg::CMD_FREE, 0, 0);
		send_word(bba_pkg::CMD_FREE, 0, 0);
		send_word(bba_pkg::CMD_FREE, 0, 1);
		send_word(bba_pkg::CMD_FREE, 0, 3);
		send_word(bba_pkg::CMD_FREE, 0, 2);
		send_word(bba_pkg::CMD_ALLOC, 10, 0);
		send_word(bba_pkg::CMD_ALLOC, 0, 0);
		send_word(bba_pkg::CMD_FREE, 0, 1);
		send_word(bba_pkg::CMD_ALLOC, 1, 0);
		send_word(bba_pkg::CMD_ALLOC, 0, 0);
		send_word(bba_pkg::CMD_FREE, 1, 2);
		send_word(bba_pkg::CMD_FREE, 0, 1023);
		send_word(bba_pkg::CMD_ALLOC, 0, 0);
		send_word(bba_pkg::CMD_FREE, 3, 1023);

		// Heap of one block at the very top of the block number range.
		set_heap(1048575, 1048576);
		send_word(bba_pkg::CMD_FREE, 0, 1048575);
		send_word(bba_pkg::CMD_ALLOC, 0, 0);
		send_word(bba_pkg::CMD_ALLOC, 0, 0);
		send_word(bba_pkg::CMD_FREE, 10, 1048575);

		// Empty heap: its end lies below its start.
		set_heap(500, 0);
		send_word(bba_pkg::CMD_FREE, 0, 600);
		send_word(bba_pkg::CMD_ALLOC, 0, 0);

		// Random phases, each over a freshly filled heap.
		for (int phase = 0; phase < 3; phase++) begin
			unique case (phase)
				0: begin
					send_idle_pct = 9;
					recv_idle_pct = 61;
					heap_lo = $urandom_range(0, 4000);
					heap_span = 48;
				end
				1: begin
					send_idle_pct = 61;
					recv_idle_pct = 9;
					heap_lo = 1048576 - 40;
					heap_span = 40;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					heap_lo = $urandom_range(0, 1048575 - 100);
					heap_span = 64;
				end
			endcase
			set_heap(heap_lo, heap_lo + heap_span);
			fill.delete();
			for (int b = 0; b < heap_span; b++)
				fill.push_back(heap_lo + b);
			fill.shuffle();
			foreach (fill[b])
				send_word(bba_pkg::CMD_FREE, 0, fill[b]);
			random_traffic(290);
		end

		drain_responses();
		repeat (120) @(posedge clk);
		if (errors == 0)
			$display("PASS buddy_block_allocator");
		else
			$display("FAIL buddy_block_allocator");
		$finish;
	end

endmodule

### filelist.f
hdl/bba_pkg.sv
hdl/bba_ram.sv
hdl/buddy_block_allocator.sv
tb/bba_checker.sv
tb/buddy_block_allocator_test.sv
